// ===== src/srpd_pkg.sv =====
package srpd_pkg;

    localparam int SymbolBytes = 32;
    localparam int SYM_W       = SymbolBytes * 8;
    localparam int POS_W       = $clog2(SymbolBytes);
    localparam int TAIL_W      = POS_W + 1;
    localparam int RUN_W       = 25;
    localparam int ACC_W       = 24;
    localparam int TOTAL_W     = 64;
    localparam int WORD_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [RUN_W-1:0] RUN_SINGLE = 25'd1;
    localparam logic [RUN_W-1:0] BIAS_ONE   = 25'd2;
    localparam logic [RUN_W-1:0] BIAS_TWO   = 25'd258;
    localparam logic [RUN_W-1:0] BIAS_THREE = 25'd65794;
    localparam logic [RUN_W-1:0] RUN_MAX    = 25'd16843009;

    typedef logic [SymbolBytes-1:0][7:0] sym_t;

    typedef struct packed {
        logic             clear;
        logic             write_en;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic             finish;
        logic [RUN_W-1:0] run;
    } cmd_t;

    function automatic logic [RUN_W-1:0] run_of(input logic [1:0] len_code,
                                                 input logic [ACC_W-1:0] acc);
        logic [RUN_W-1:0] run;
        unique case (len_code)
            LEN_NONE:  run = RUN_SINGLE;
            LEN_ONE:   run = RUN_W'(acc) + BIAS_ONE;
            LEN_TWO:   run = RUN_W'(acc) + BIAS_TWO;
            LEN_THREE: run = RUN_W'(acc) + BIAS_THREE;
            default:   run = RUN_SINGLE;
        endcase
        return run;
    endfunction

endpackage

// ===== src/srpd_front.sv =====
module srpd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_stream_byte,
    input  logic                  s_stream_start,
    output logic                  cmd_valid,
    output srpd_pkg::cmd_t        cmd,
    input  logic                  cmd_ready
);

    logic [srpd_pkg::TAIL_W-1:0] tail_reg, tail_next;
    logic [srpd_pkg::POS_W-1:0]  wpos_reg, wpos_next;
    logic [1:0]                  ltot_reg, ltot_next;
    logic [1:0]                  lrem_reg, lrem_next;
    logic [srpd_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                        accept;
    logic                        awaiting;
    logic [srpd_pkg::POS_W-1:0]  kept;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;
    assign awaiting  = s_stream_start || (tail_reg == '0 && lrem_reg == '0);
    assign kept      = s_stream_byte[srpd_pkg::POS_W-1:0];

    always_comb begin
        tail_next = tail_reg;
        wpos_next = wpos_reg;
        ltot_next = ltot_reg;
        lrem_next = lrem_reg;
        acc_next  = acc_reg;
        cmd       = '0;
        if (awaiting) begin
            // A start beat always carries an opcode, so the parser restarts here.
            tail_next = srpd_pkg::TAIL_W'(srpd_pkg::SymbolBytes) - {1'b0, kept};
            wpos_next = kept;
            ltot_next = s_stream_byte[6:5];
            lrem_next = s_stream_byte[6:5];
            acc_next  = '0;
            cmd.clear = s_stream_start;
        end else if (tail_reg != '0) begin
            cmd.write_en = 1'b1;
            cmd.pos      = wpos_reg;
            cmd.data     = s_stream_byte;
            wpos_next    = wpos_reg + 1'b1;
            tail_next    = tail_reg - 1'b1;
            cmd.finish   = (tail_reg == srpd_pkg::TAIL_W'(1)) && (lrem_reg == '0);
        end else begin
            acc_next   = {acc_reg[srpd_pkg::ACC_W-9:0], s_stream_byte};
            lrem_next  = lrem_reg - 1'b1;
            cmd.finish = (lrem_reg == 2'd1);
        end
        if (cmd.finish) begin
            cmd.run   = srpd_pkg::run_of(ltot_reg, acc_next);
            ltot_next = '0;
            acc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg <= '0;
            wpos_reg <= '0;
            ltot_reg <= '0;
            lrem_reg <= '0;
            acc_reg  <= '0;
        end else if (accept) begin
            tail_reg <= tail_next;
            wpos_reg <= wpos_next;
            ltot_reg <= ltot_next;
            lrem_reg <= lrem_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== src/srpd_queue.sv =====
module srpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  srpd_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output srpd_pkg::cmd_t out_cmd
);

    srpd_pkg::cmd_t                   entry_reg [srpd_pkg::QUEUE_DEPTH];
    logic [srpd_pkg::QUEUE_PTR_W-1:0] wptr_reg;
    logic [srpd_pkg::QUEUE_PTR_W-1:0] rptr_reg;
    logic [srpd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                             push;
    logic                             pop;

    assign in_ready  = (count_reg != srpd_pkg::QUEUE_CNT_W'(srpd_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/srpd_back.sv =====
module srpd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  srpd_pkg::cmd_t                 cmd,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word0,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word1,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word2,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word3,
    output logic [srpd_pkg::RUN_W-1:0]     m_run_length,
    output logic [srpd_pkg::TOTAL_W-1:0]   m_symbols_so_far
);

    srpd_pkg::sym_t                sym_reg, sym_next;
    srpd_pkg::sym_t                merged;
    logic [srpd_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic                          m_valid_reg, m_valid_next;
    srpd_pkg::sym_t                out_sym_reg;
    logic [srpd_pkg::RUN_W-1:0]    out_run_reg;
    logic [srpd_pkg::TOTAL_W-1:0]  out_total_reg;
    logic                          slot_free;
    logic                          pop;
    logic                          emit;

    assign slot_free = !m_valid_reg || m_ready;
    assign cmd_ready = !cmd.finish || slot_free;
    assign pop       = cmd_valid && cmd_ready;
    assign emit      = pop && !cmd.clear && cmd.finish;

    always_comb begin
        merged = sym_reg;
        // Byte 0 of the symbol sits in the top element of the packed array.
        if (cmd.write_en) begin
            merged[~cmd.pos] = cmd.data;
        end
    end

    always_comb begin
        sym_next   = sym_reg;
        total_next = total_reg;
        if (pop) begin
            if (cmd.clear) begin
                sym_next   = '0;
                total_next = '0;
            end else if (cmd.finish) begin
                sym_next   = srpd_pkg::sym_t'(srpd_pkg::SYM_W'(merged)
                                              + srpd_pkg::SYM_W'(cmd.run));
                total_next = total_reg + srpd_pkg::TOTAL_W'(cmd.run);
            end else begin
                sym_next = merged;
            end
        end
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sym_reg     <= sym_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_sym_reg   <= merged;
            out_run_reg   <= cmd.run;
            out_total_reg <= total_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_start_word0    = out_sym_reg[31:24];
    assign m_start_word1    = out_sym_reg[23:16];
    assign m_start_word2    = out_sym_reg[15:8];
    assign m_start_word3    = out_sym_reg[7:0];
    assign m_run_length     = out_run_reg;
    assign m_symbols_so_far = out_total_reg;

endmodule

// ===== src/symbol_run_prefix_decoder_unit.sv =====
// Decodes a stream of run records into runs of 256-bit symbols.
// The input channel takes one byte per beat with a stream start flag; a start
// beat clears the running symbol, the parser and the symbol total, and the byte
// that comes with it is read as an opcode. The result channel gives one beat
// per completed record: the start symbol as four big-endian 64-bit words, the
// run length and the total of run lengths since the stream start.
// Throughput is one input beat per cycle while the command queue has room,
// and an input beat is never held up by record parsing. The beat that
// completes a record reaches the result channel through the command queue and
// the output register: the parser is combinational and writes the queue at the
// accepting edge, and the symbol unit, whose path holds the 256-bit addition
// of the run length, then loads the output register.
// When the receiver stalls, the result waits in the output register, the
// symbol unit stops at the next completing record, and the two-entry queue
// fills, after which s_ready falls until a result beat is taken.
// Reset is synchronous and active low; after it the symbol and the total are
// zero, the parser awaits an opcode and no result is pending.
module symbol_run_prefix_decoder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_stream_byte,
    input  logic                           s_stream_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word0,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word1,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word2,
    output logic [srpd_pkg::WORD_W-1:0]    m_start_word3,
    output logic [srpd_pkg::RUN_W-1:0]     m_run_length,
    output logic [srpd_pkg::TOTAL_W-1:0]   m_symbols_so_far
);

    logic           front_valid;
    logic           front_ready;
    srpd_pkg::cmd_t front_cmd;
    logic           back_valid;
    logic           back_ready;
    srpd_pkg::cmd_t back_cmd;

    srpd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_stream_byte  (s_stream_byte),
        .s_stream_start (s_stream_start),
        .cmd_valid      (front_valid),
        .cmd            (front_cmd),
        .cmd_ready      (front_ready)
    );

    srpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    srpd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (back_valid),
        .cmd_ready        (back_ready),
        .cmd              (back_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_word0    (m_start_word0),
        .m_start_word1    (m_start_word1),
        .m_start_word2    (m_start_word2),
        .m_start_word3    (m_start_word3),
        .m_run_length     (m_run_length),
        .m_symbols_so_far (m_symbols_so_far)
    );

endmodule

// ===== src/srpd_checker.sv =====
module srpd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [srpd_pkg::WORD_W-1:0]    m_start_word0,
    input logic [srpd_pkg::WORD_W-1:0]    m_start_word1,
    input logic [srpd_pkg::WORD_W-1:0]    m_start_word2,
    input logic [srpd_pkg::WORD_W-1:0]    m_start_word3,
    input logic [srpd_pkg::RUN_W-1:0]     m_run_length,
    input logic [srpd_pkg::TOTAL_W-1:0]   m_symbols_so_far
);

    // A result beat that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_start_word0)
            && $stable(m_start_word1) && $stable(m_start_word2)
            && $stable(m_start_word3) && $stable(m_run_length)
            && $stable(m_symbols_so_far))
        else $error("result beat changed while stalled");

    // Every run covers at least one symbol and no more than the largest coded run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_run_length != '0 && m_run_length <= srpd_pkg::RUN_MAX)
        else $error("run length out of range");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat pending after reset");

    // A result can only follow an accepted input beat, never appear from idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(m_valid) && m_valid |-> $past(s_valid && s_ready, 2)
            || $past(m_valid, 2) || $past(!aresetn, 2) || $past(!s_ready, 2))
        else $error("result beat without a preceding input beat");

endmodule

bind symbol_run_prefix_decoder_unit srpd_checker u_srpd_checker (.*);

// ===== verif/symbol_run_prefix_decoder_unit_tb.sv =====
module symbol_run_prefix_decoder_unit_tb;

    localparam int RANDOM_BYTES   = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RESET_CYCLES   = 7;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } stream_beat_t;

    typedef struct {
        logic [srpd_pkg::WORD_W-1:0]  w0;
        logic [srpd_pkg::WORD_W-1:0]  w1;
        logic [srpd_pkg::WORD_W-1:0]  w2;
        logic [srpd_pkg::WORD_W-1:0]  w3;
        logic [srpd_pkg::RUN_W-1:0]   run;
        logic [srpd_pkg::TOTAL_W-1:0] total;
    } run_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_stream_byte = 8'h00;
    logic                           s_stream_start = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [srpd_pkg::WORD_W-1:0]    m_start_word0;
    logic [srpd_pkg::WORD_W-1:0]    m_start_word1;
    logic [srpd_pkg::WORD_W-1:0]    m_start_word2;
    logic [srpd_pkg::WORD_W-1:0]    m_start_word3;
    logic [srpd_pkg::RUN_W-1:0]     m_run_length;
    logic [srpd_pkg::TOTAL_W-1:0]   m_symbols_so_far;

    symbol_run_prefix_decoder_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .s_stream_start   (s_stream_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_word0    (m_start_word0),
        .m_start_word1    (m_start_word1),
        .m_start_word2    (m_start_word2),
        .m_start_word3    (m_start_word3),
        .m_run_length     (m_run_length),
        .m_symbols_so_far (m_symbols_so_far)
    );

    stream_beat_t stream_q[$];
    run_result_t  expected_runs[$];
    stream_beat_t next_beat;
    run_result_t  want;

    // Decoder state as the block should hold it.
    logic [srpd_pkg::SYM_W-1:0]   cur_symbol;
    logic [srpd_pkg::TAIL_W-1:0]  tail_left;
    logic [srpd_pkg::POS_W-1:0]   wr_pos;
    logic [1:0]                   len_total;
    logic [1:0]                   len_left;
    logic [srpd_pkg::ACC_W-1:0]   len_acc;
    logic [srpd_pkg::TOTAL_W-1:0] sym_count;

    int beats_driven = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int starts_seen = 0;
    int max_runs = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int ready_mode = 0;
    int ready_phase = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic clear_decoder();
        cur_symbol = '0;
        tail_left  = '0;
        wr_pos     = '0;
        len_total  = srpd_pkg::LEN_NONE;
        len_left   = srpd_pkg::LEN_NONE;
        len_acc    = '0;
        sym_count  = '0;
    endtask

    task automatic absorb_stream_byte(input logic [7:0] b, input logic start);
        logic [srpd_pkg::RUN_W-1:0] run;
        run_result_t                res;
        bit                         finish;
        finish = 1'b0;
        if (start) begin
            clear_decoder();
            starts_seen++;
        end
        if (tail_left == 0 && len_left == 0) begin
            wr_pos    = b[srpd_pkg::POS_W-1:0];
            tail_left = srpd_pkg::TAIL_W'(srpd_pkg::SymbolBytes)
                        - srpd_pkg::TAIL_W'(b[srpd_pkg::POS_W-1:0]);
            len_total = b[6:5];
            len_left  = b[6:5];
            len_acc   = '0;
        end else if (tail_left != 0) begin
            cur_symbol[srpd_pkg::SYM_W-1-8*int'(wr_pos) -: 8] = b;
            wr_pos    = wr_pos + 1'b1;
            tail_left = tail_left - 1'b1;
            finish    = (tail_left == 0 && len_left == 0);
        end else begin
            len_acc  = {len_acc[srpd_pkg::ACC_W-9:0], b};
            len_left = len_left - 1'b1;
            finish   = (len_left == 0);
        end
        if (finish) begin
            case (len_total)
                srpd_pkg::LEN_ONE:
                    run = srpd_pkg::RUN_W'(len_acc) + srpd_pkg::BIAS_ONE;
                srpd_pkg::LEN_TWO:
                    run = srpd_pkg::RUN_W'(len_acc) + srpd_pkg::BIAS_TWO;
                srpd_pkg::LEN_THREE:
                    run = srpd_pkg::RUN_W'(len_acc) + srpd_pkg::BIAS_THREE;
                default:
                    run = srpd_pkg::RUN_SINGLE;
            endcase
            sym_count = sym_count + srpd_pkg::TOTAL_W'(run);
            res.w0    = cur_symbol[srpd_pkg::SYM_W-1 -: srpd_pkg::WORD_W];
            res.w1    = cur_symbol[srpd_pkg::SYM_W-1-srpd_pkg::WORD_W -: srpd_pkg::WORD_W];
            res.w2    = cur_symbol[srpd_pkg::SYM_W-1-2*srpd_pkg::WORD_W -: srpd_pkg::WORD_W];
            res.w3    = cur_symbol[srpd_pkg::SYM_W-1-3*srpd_pkg::WORD_W -: srpd_pkg::WORD_W];
            res.run   = run;
            res.total = sym_count;
            expected_runs.push_back(res);
            if (run == srpd_pkg::RUN_MAX) begin
                max_runs++;
            end
            cur_symbol = cur_symbol + srpd_pkg::SYM_W'(run);
            len_total  = srpd_pkg::LEN_NONE;
            len_acc    = '0;
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on %s in result %0d: expected %h, got %h",
                         field, results_seen, exp_val, got);
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start);
        stream_beat_t sb;
        sb.data  = b;
        sb.start = start;
        stream_q.push_back(sb);
    endtask

    // A record keeping the given number of leading bytes; cut limits how many of
    // its bytes are sent, so that a value below the full size leaves it broken.
    task automatic queue_record(input bit with_start, input int kept, input bit all_ones,
                                input int cut);
        int len_code;
        int tail;
        int len_style;
        int sent;
        logic [7:0] b;
        len_code  = $urandom_range(0, 3);
        tail      = srpd_pkg::SymbolBytes - kept;
        len_style = $urandom_range(0, 7);
        push_byte({1'($urandom), 2'(len_code), 5'(kept)}, with_start);
        sent = 1;
        for (int i = 0; i < tail + len_code; i++) begin
            if (sent < cut) begin
                if (i < tail) begin
                    b = all_ones ? 8'hFF : 8'($urandom);
                end else if (len_style < 2) begin
                    b = 8'hFF;
                end else if (len_style == 2) begin
                    b = 8'h00;
                end else begin
                    b = 8'($urandom);
                end
                push_byte(b, 1'b0);
                sent++;
            end
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beats_taken == beats_driven) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
                next_beat = stream_q.pop_front();
                s_stream_byte  <= next_beat.data;
                s_stream_start <= next_beat.start;
                s_valid        <= 1'b1;
                beats_driven++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The receiver cycles through its own stall patterns and once holds off
    // long enough for the block to fill up and stall the input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ready_phase[2];
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            ready_phase++;
            if (ready_phase % 50 == 0) begin
                ready_mode = $urandom_range(0, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (s_valid && s_ready) begin
                absorb_stream_byte(s_stream_byte, s_stream_start);
                beats_taken++;
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                results_seen++;
                if (expected_runs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result %0d: run %0d, total %0d",
                                 results_seen, m_run_length, m_symbols_so_far);
                    end
                end else begin
                    want = expected_runs.pop_front();
                    check_field("start_word0", m_start_word0, want.w0);
                    check_field("start_word1", m_start_word1, want.w1);
                    check_field("start_word2", m_start_word2, want.w2);
                    check_field("start_word3", m_start_word3, want.w3);
                    check_field("run_length", 64'(m_run_length), 64'(want.run));
                    check_field("symbols_so_far", m_symbols_so_far, want.total);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("symbol_run_prefix_decoder_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int target;
        int pick;
        int kept;
        int cut;
        bit next_start;

        clear_decoder();

        // Single- and two-byte tails with each length size, the largest run, a start
        // that breaks a record, and an opcode with its ignored top bit set.
        push_byte(8'h1F, 1'b1); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h3F, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h5F, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
        push_byte(8'h7E, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h1C, 1'b0); push_byte(8'h55, 1'b0);
        push_byte(8'h1F, 1'b1); push_byte(8'hAA, 1'b0);

        // A whole symbol of ones followed by a run that wraps it.
        push_byte(8'h20, 1'b0);
        repeat (srpd_pkg::SymbolBytes) push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);

        target = stream_q.size() + RANDOM_BYTES;
        next_start = 1'b0;
        while (stream_q.size() < target) begin
            pick = $urandom_range(0, 49);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
                next_start = ($urandom_range(0, 3) != 0);
            end else begin
                case ($urandom_range(0, 19)) inside
                    [0:9]:   kept = srpd_pkg::SymbolBytes - 1;
                    [10:14]: kept = $urandom_range(24, 30);
                    [15:18]: kept = $urandom_range(1, 23);
                    default: kept = 0;
                endcase
                cut = (pick < 3) ? $urandom_range(1, 3) : srpd_pkg::SymbolBytes + 8;
                queue_record(next_start || $urandom_range(0, 15) == 0, kept,
                             $urandom_range(0, 15) == 0, cut);
                next_start = (pick < 3);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stream_q.size() != 0 || beats_taken != beats_driven ||
               expected_runs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d input bytes, %0d stream starts and %0d result beats,",
                 beats_taken, starts_seen, results_seen);
        $display("with %0d runs of the largest length and one long receiver hold-off.",
                 max_runs);
        if (mismatches == 0 && expected_runs.size() == 0) begin
            $display("symbol_run_prefix_decoder_unit_tb: PASS");
        end else begin
            $display("symbol_run_prefix_decoder_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
